@@ sv/ppmrcd_pkg.sv @@
// Shared types and constants for the PPM receiver channel decoder.
package ppmrcd_pkg;

    localparam int NUM_SLOTS = 9;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

    localparam int TIME_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [TIME_W-1:0] SYNC_THRESHOLD_RST = 16'd2100;

    localparam logic [TIME_W-1:0] DEF_ROLL     = 16'd1500;
    localparam logic [TIME_W-1:0] DEF_PITCH    = 16'd1500;
    localparam logic [TIME_W-1:0] DEF_THROTTLE = 16'd1000;
    localparam logic [TIME_W-1:0] DEF_YAW      = 16'd1500;

    localparam logic [TIME_W-1:0] SW_LOW_MIN  = 16'd900;
    localparam logic [TIME_W-1:0] SW_MID_MIN  = 16'd1400;
    localparam logic [TIME_W-1:0] SW_MID_LIM  = 16'd1800;

    localparam logic [TIME_W-1:0] SLOT_RESET [16] = '{
        16'd1500, 16'd1500, 16'd1000, 16'd1500, 16'd1500, 16'd2000, 16'd1500, 16'd0,
        16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0
    };

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;

    typedef enum logic [1:0] {
        FUNC_CAPTURE = 2'd0,
        FUNC_STICKS  = 2'd1,
        FUNC_SWITCH  = 2'd2
    } t_func;

    typedef enum logic [2:0] {
        SW_OFF       = 3'd0,
        SW_OFF_TO_ON = 3'd1,
        SW_ON        = 3'd2,
        SW_ON_TO_OFF = 3'd3,
        SW_ON_PLUS   = 3'd4
    } t_sw_code;

    typedef struct packed {
        logic [1:0]        func;
        logic [TIME_W-1:0] capture_time;
    } t_in_item;

    typedef struct packed {
        logic [TIME_W-1:0] roll;
        logic [TIME_W-1:0] pitch;
        logic [TIME_W-1:0] throttle;
        logic [TIME_W-1:0] yaw;
        logic [2:0]        switch_state;
        logic              width_written;
        logic [3:0]        slot_written;
        logic [TIME_W-1:0] pulse_width;
    } t_out_item;

    typedef struct packed {
        logic              written;
        logic [3:0]        slot;
        logic [TIME_W-1:0] width;
    } t_cap_res;

    typedef struct packed {
        logic [TIME_W-1:0] roll;
        logic [TIME_W-1:0] pitch;
        logic [TIME_W-1:0] throttle;
        logic [TIME_W-1:0] yaw;
        logic [TIME_W-1:0] aux;
    } t_slot_view;

endpackage

@@ sv/ppmrcd_slots.sv @@
// Slot table, slot counter and edge time register of the PPM decoder.
module ppmrcd_slots (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_capture,
    input  logic [ppmrcd_pkg::TIME_W-1:0] i_time,
    input  logic [ppmrcd_pkg::TIME_W-1:0] i_threshold,
    output ppmrcd_pkg::t_cap_res       o_cap,
    output ppmrcd_pkg::t_slot_view     o_view
);
    import ppmrcd_pkg::*;

    logic [TIME_W-1:0] r_slot [NUM_SLOTS];
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic [TIME_W-1:0] r_last;
    logic              can_write;
    logic [SLOT_W-1:0] slot_idx;
    logic [TIME_W-1:0] width;

    assign can_write = (r_cnt < CNT_W'(NUM_SLOTS)) && (r_last != '0);
    assign slot_idx  = r_cnt[SLOT_W-1:0];
    assign width     = i_time - r_last;

    always_comb begin
        o_cap = '0;
        if (can_write) begin
            o_cap.written = 1'b1;
            o_cap.slot    = 4'(slot_idx);
            o_cap.width   = width;
        end
    end

    always_comb begin
        if (!can_write || width > i_threshold) begin
            n_cnt = '0;
        end else begin
            n_cnt = r_cnt + CNT_W'(1);
        end
    end

    assign o_view.roll     = r_slot[0];
    assign o_view.pitch    = r_slot[1];
    assign o_view.throttle = r_slot[2];
    assign o_view.yaw      = r_slot[3];
    assign o_view.aux      = r_slot[5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_slot[i] <= SLOT_RESET[i];
            end
            r_cnt  <= '0;
            r_last <= '0;
        end else if (i_capture) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (can_write && slot_idx == SLOT_W'(i)) begin
                    r_slot[i] <= width;
                end
            end
            r_cnt  <= n_cnt;
            r_last <= i_time;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(NUM_SLOTS))
        else $error("slot counter beyond slot count");

    a_cnt_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_capture && !can_write |=> r_cnt == '0)
        else $error("slot counter did not restart after a capture without a write");

endmodule

@@ sv/ppm_receiver_channel_decoder.sv @@
// Top level of the PPM receiver channel decoder.
// An accepted item's result is registered in r_out, or in the skid entry if r_out is stalled.
// One item per cycle unless the skid is full; subtract and switch compare sit in one stage.
// An output register with a skid entry behind it keeps accepting while a result waits,
// and the input stall comes straight from the skid valid flop.
// Synchronous active-low reset restores slots, counters, switch memory, config, valid flags.
module ppm_receiver_channel_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  ppmrcd_pkg::t_in_item          i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output ppmrcd_pkg::t_out_item         o_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ppmrcd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ppmrcd_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import ppmrcd_pkg::*;

    logic              r_enable;
    logic [TIME_W-1:0] r_threshold;
    logic              r_sw_on;
    logic              n_sw_on;
    logic              r_out_valid;
    t_out_item         r_out;
    logic              r_skid_valid;
    t_out_item         r_skid;
    t_out_item         n_res;
    logic              in_acc;
    logic              out_fire;
    logic              capture;
    t_cap_res          cap;
    t_slot_view        view;

    assign in_acc      = i_in_valid && !r_skid_valid;
    assign out_fire    = r_out_valid && !i_out_stall;
    assign capture     = in_acc && (i_in.func == FUNC_CAPTURE);
    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    ppmrcd_slots u_slots (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_capture   (capture),
        .i_time      (i_in.capture_time),
        .i_threshold (r_threshold),
        .o_cap       (cap),
        .o_view      (view)
    );

    always_comb begin
        n_res   = '0;
        n_sw_on = r_sw_on;
        case (i_in.func)
            FUNC_CAPTURE: begin
                n_res.width_written = cap.written;
                n_res.slot_written  = cap.slot;
                n_res.pulse_width   = cap.width;
            end
            FUNC_STICKS: begin
                if (r_enable) begin
                    n_res.roll     = view.roll;
                    n_res.pitch    = view.pitch;
                    n_res.throttle = view.throttle;
                    n_res.yaw      = view.yaw;
                end else begin
                    n_res.roll     = DEF_ROLL;
                    n_res.pitch    = DEF_PITCH;
                    n_res.throttle = DEF_THROTTLE;
                    n_res.yaw      = DEF_YAW;
                end
            end
            FUNC_SWITCH: begin
                if (view.aux >= SW_LOW_MIN && view.aux < SW_MID_MIN) begin
                    n_res.switch_state = SW_ON_PLUS;
                end else if (view.aux >= SW_MID_MIN && view.aux < SW_MID_LIM) begin
                    n_res.switch_state = r_sw_on ? SW_ON : SW_OFF_TO_ON;
                    n_sw_on = 1'b1;
                end else begin
                    n_res.switch_state = r_sw_on ? SW_ON_TO_OFF : SW_OFF;
                    n_sw_on = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_threshold <= SYNC_THRESHOLD_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ENABLE:    r_enable    <= i_cfg_data[0];
                CFG_THRESHOLD: r_threshold <= i_cfg_data[TIME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw_on <= 1'b0;
        end else if (in_acc) begin
            r_sw_on <= n_sw_on;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (in_acc) begin
            if (r_out_valid && i_out_stall) begin
                r_skid       <= n_res;
                r_skid_valid <= 1'b1;
            end else begin
                r_out       <= n_res;
                r_out_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without an output item");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && i_out_stall |=> r_skid_valid && $stable(r_skid))
        else $error("skid entry lost while output stalled");

    a_capture_only_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.width_written |->
            o_out.switch_state == '0 && o_out.roll == '0 && o_out.yaw == '0)
        else $error("capture item carries stick or switch data");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_out_valid)
        else $error("accepted item produced no output");

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the PPM receiver channel decoder: directed table, random frames.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ppmrcd_pkg::*;

    localparam logic [1:0]  FUNC_UNUSED = 2'd3;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          SEGS        = 4;
    localparam int          SEG_ITEMS   = 125;
    localparam int          SEG_GAP   [SEGS] = '{10, 82, 0, 0};
    localparam int          SEG_STALL [SEGS] = '{82, 10, 0, 0};
    localparam logic        SEG_ENABLE [SEGS] = '{1'b1, 1'b0, 1'b1, 1'b1};
    localparam logic [15:0] SEG_SYNC   [SEGS] = '{16'd2100, 16'd0, 16'hFFFF, 16'd1800};

    localparam t_out_item QUIET = '0;
    localparam t_out_item STICKS_DISABLED = '{roll: DEF_ROLL, pitch: DEF_PITCH,
                                              throttle: DEF_THROTTLE, yaw: DEF_YAW,
                                              default: '0};

    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] cfg_index;
        t_in_item             item;
        logic                 typed;
        t_out_item            want;
    } t_dir_row;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in        = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data  = '0;

    // Predictor state and register copies.
    logic [TIME_W-1:0] chan_width [NUM_SLOTS];
    int unsigned       frame_slot;
    logic [TIME_W-1:0] prev_edge;
    logic              aux_on;
    logic              rx_enable;
    logic [TIME_W-1:0] sync_limit;

    t_out_item         expected_results [$];
    t_out_item         oldest;
    t_dir_row          dir_tab [$];
    int                err_count   = 0;
    int unsigned       cycle_count = 0;
    int                gap_pct     = 0;
    int                stall_pct   = 0;
    logic [TIME_W-1:0] edge_clock  = 16'd19299;
    int                pulses_left = 0;

    ppm_receiver_channel_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    function automatic t_out_item decode_item(t_in_item it);
        t_out_item         r;
        logic [TIME_W-1:0] w;
        logic [TIME_W-1:0] v;
        r = '0;
        case (it.func)
            FUNC_CAPTURE: begin
                if (frame_slot < NUM_SLOTS && prev_edge != '0) begin
                    w = it.capture_time - prev_edge;
                    chan_width[frame_slot] = w;
                    r.width_written = 1'b1;
                    r.slot_written  = 4'(frame_slot);
                    r.pulse_width   = w;
                    frame_slot = (w > sync_limit) ? 0 : frame_slot + 1;
                end else begin
                    frame_slot = 0;
                end
                prev_edge = it.capture_time;
            end
            FUNC_STICKS: begin
                if (rx_enable) begin
                    r.roll     = chan_width[0];
                    r.pitch    = chan_width[1];
                    r.throttle = chan_width[2];
                    r.yaw      = chan_width[3];
                end else begin
                    r = STICKS_DISABLED;
                end
            end
            FUNC_SWITCH: begin
                v = chan_width[5];
                if (v >= SW_LOW_MIN && v < SW_MID_MIN) begin
                    r.switch_state = SW_ON_PLUS;
                end else if (v >= SW_MID_MIN && v < SW_MID_LIM) begin
                    r.switch_state = aux_on ? SW_ON : SW_OFF_TO_ON;
                    aux_on = 1'b1;
                end else begin
                    r.switch_state = aux_on ? SW_ON_TO_OFF : SW_OFF;
                    aux_on = 1'b0;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Mostly well-formed frames of pulses closed by a sync gap, mixed with reads and noise.
    function automatic t_in_item next_ppm_item();
        t_in_item    it;
        int unsigned sel;
        int unsigned top;
        sel = $urandom_range(0, 99);
        it.capture_time = 16'($urandom_range(0, 65535));
        if (sel < 62) begin
            if (pulses_left == 0) begin
                top = (sync_limit > 16'd60535) ? 65535 : sync_limit + 5000;
                if (sync_limit == 16'hFFFF) begin
                    edge_clock += 16'($urandom_range(2200, 65535));
                end else begin
                    edge_clock += 16'($urandom_range(sync_limit + 1, top));
                end
                pulses_left = $urandom_range(3, 11);
            end else begin
                edge_clock += 16'($urandom_range(800, 2200));
                pulses_left--;
            end
            it.func = FUNC_CAPTURE;
            it.capture_time = edge_clock;
        end else if (sel < 76) begin
            it.func = FUNC_STICKS;
        end else if (sel < 90) begin
            it.func = FUNC_SWITCH;
        end else if (sel < 96) begin
            it.func = FUNC_CAPTURE;
            if ($urandom_range(0, 3) == 0) begin
                it.capture_time = '0;
            end
        end else begin
            it.func = FUNC_UNUSED;
        end
        return it;
    endfunction

    function automatic t_dir_row item_row(logic [1:0] func, logic [TIME_W-1:0] stamp,
                                          logic typed, t_out_item want);
        t_dir_row r;
        r = '0;
        r.item.func         = func;
        r.item.capture_time = stamp;
        r.typed             = typed;
        r.want              = want;
        return r;
    endfunction

    function automatic t_dir_row cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        t_dir_row r;
        r = '0;
        r.is_cfg            = 1'b1;
        r.cfg_index         = idx;
        r.item.capture_time = data;
        return r;
    endfunction

    function automatic t_out_item cap_out(logic [3:0] slot, logic [TIME_W-1:0] width);
        t_out_item r;
        r = '0;
        r.width_written = 1'b1;
        r.slot_written  = slot;
        r.pulse_width   = width;
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
        err_count++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected item", o_out.pulse_width, '0);
            end else begin
                oldest = expected_results.pop_front();
                if (o_out.roll !== oldest.roll)
                    report_mismatch("roll", o_out.roll, oldest.roll);
                if (o_out.pitch !== oldest.pitch)
                    report_mismatch("pitch", o_out.pitch, oldest.pitch);
                if (o_out.throttle !== oldest.throttle)
                    report_mismatch("throttle", o_out.throttle, oldest.throttle);
                if (o_out.yaw !== oldest.yaw)
                    report_mismatch("yaw", o_out.yaw, oldest.yaw);
                if (o_out.switch_state !== oldest.switch_state)
                    report_mismatch("switch_state", 16'(o_out.switch_state),
                                    16'(oldest.switch_state));
                if (o_out.width_written !== oldest.width_written)
                    report_mismatch("width_written", 16'(o_out.width_written),
                                    16'(oldest.width_written));
                if (o_out.slot_written !== oldest.slot_written)
                    report_mismatch("slot_written", 16'(o_out.slot_written),
                                    16'(oldest.slot_written));
                if (o_out.pulse_width !== oldest.pulse_width)
                    report_mismatch("pulse_width", o_out.pulse_width, oldest.pulse_width);
            end
        end
    end

    task automatic send_item(input t_in_item it, input logic typed, input t_out_item want);
        t_out_item predicted;
        while ($urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        do @(posedge i_clk); while (o_in_stall);
        predicted = decode_item(it);
        expected_results.push_back(typed ? want : predicted);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        drain_results();
        repeat (2) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_ENABLE:    rx_enable  = data[0];
            CFG_THRESHOLD: sync_limit = data;
            default: begin
            end
        endcase
    endtask

    initial begin
        for (int k = 0; k < NUM_SLOTS; k++) begin
            chan_width[k] = SLOT_RESET[k];
        end
        frame_slot = 0;
        prev_edge  = '0;
        aux_on     = 1'b0;
        rx_enable  = 1'b0;
        sync_limit = SYNC_THRESHOLD_RST;

        // Slot 5 resets outside every switch band, so the first switch read is off.
        dir_tab = '{
            item_row(FUNC_STICKS,  16'h0000, 1'b1, STICKS_DISABLED),
            item_row(FUNC_SWITCH,  16'hFFFF, 1'b1, QUIET),
            item_row(FUNC_UNUSED,  16'h5A5A, 1'b1, QUIET),
            item_row(FUNC_CAPTURE, 16'd0,    1'b1, QUIET),
            item_row(FUNC_CAPTURE, 16'hFFFF, 1'b1, QUIET),
            item_row(FUNC_CAPTURE, 16'd999,  1'b1, cap_out(4'd0, 16'd1000)),
            item_row(FUNC_CAPTURE, 16'd999,  1'b1, cap_out(4'd1, 16'd0)),
            item_row(FUNC_CAPTURE, 16'd998,  1'b1, cap_out(4'd2, 16'hFFFF)),
            item_row(FUNC_CAPTURE, 16'd3099, 1'b1, cap_out(4'd0, 16'd2101)),
            item_row(FUNC_CAPTURE, 16'd5199, 1'b1, cap_out(4'd0, 16'd2100)),
            item_row(FUNC_CAPTURE, 16'd6699, 1'b0, QUIET),
            item_row(FUNC_CAPTURE, 16'd7699, 1'b0, QUIET),
            item_row(FUNC_CAPTURE, 16'd9199, 1'b0, QUIET),
            item_row(FUNC_CAPTURE, 16'd10699, 1'b0, QUIET),
            item_row(FUNC_CAPTURE, 16'd11799, 1'b0, QUIET),
            item_row(FUNC_CAPTURE, 16'd13299, 1'b0, QUIET),
            item_row(FUNC_CAPTURE, 16'd14799, 1'b0, QUIET),
            item_row(FUNC_CAPTURE, 16'd16299, 1'b0, QUIET),
            item_row(FUNC_CAPTURE, 16'd19299, 1'b1, QUIET),
            item_row(FUNC_SWITCH,  16'h0F0F, 1'b0, QUIET),
            cfg_row(CFG_ENABLE, 16'd1),
            item_row(FUNC_STICKS,  16'hF0F0, 1'b0, QUIET)
        };

        gap_pct   = SEG_GAP[0];
        stall_pct = SEG_STALL[0];
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[k]) begin
            if (dir_tab[k].is_cfg) begin
                write_reg(dir_tab[k].cfg_index, dir_tab[k].item.capture_time);
            end else begin
                send_item(dir_tab[k].item, dir_tab[k].typed, dir_tab[k].want);
            end
        end

        for (int s = 0; s < SEGS; s++) begin
            write_reg(CFG_ENABLE, 16'(SEG_ENABLE[s]));
            write_reg(CFG_THRESHOLD, SEG_SYNC[s]);
            gap_pct   = SEG_GAP[s];
            stall_pct = SEG_STALL[s];
            for (int n = 0; n < SEG_ITEMS; n++) begin
                if (n == SEG_ITEMS / 2) begin
                    drain_results();
                end
                send_item(next_ppm_item(), 1'b0, QUIET);
            end
        end

        drain_results();
        repeat (4) @(posedge i_clk);
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
